// ----- src/ossp_pkg.sv -----
package ossp_pkg;

	localparam int TAG_MAX_BYTES_DEF    = 127;
	localparam int VENDOR_MAX_BYTES_DEF = 1024;
	localparam int RQ_DEPTH             = 4;

	localparam logic [31:0] OGG_MAGIC   = 32'h5367674f;
	localparam logic [31:0] SPX_MAGIC_A = 32'h65657053;
	localparam logic [31:0] SPX_MAGIC_B = 32'h20202078;
	localparam logic [31:0] ENTRY_MAX   = 32'h0100_0000;
	localparam logic [23:0] PAGE_HDR_LEN = 24'd27;
	localparam logic [16:0] SPX_HDR_MIN  = 17'd80;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	typedef enum logic [1:0] {
		RK_HEADER = 2'd0,
		RK_TAG_START = 2'd1,
		RK_TAG_BYTE = 2'd2,
		RK_VERDICT = 2'd3
	} rkind_t;

	typedef enum logic [2:0] {
		TAG_ARTIST = 3'd0,
		TAG_TITLE = 3'd1,
		TAG_ALBUM = 3'd2,
		TAG_GENRE = 3'd3,
		TAG_COMPOSER = 3'd4
	} tag_t;

	typedef enum logic [3:0] {
		PH_IDLE, PH_P1_HDR, PH_P1_LACE, PH_P1_BODY, PH_P2_HDR, PH_P2_LACE,
		PH_VEND_LEN, PH_VEND_SKIP, PH_COUNT, PH_ENTRY_LEN, PH_ENTRY_BODY, PH_DONE
	} phase_t;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic [31:0]        sample_rate;
		logic [31:0]        coding_mode;
		logic [31:0]        channel_count;
		logic signed [31:0] nominal_bitrate;
		logic               variable_rate;
		logic [2:0]         tag_id;
		logic [7:0]         tag_byte;
		logic               is_speex;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic logic [3:0] tag_len(input logic [2:0] c);
		logic [3:0] l;
		unique case (c)
			TAG_ARTIST:   l = 4'd7;
			TAG_COMPOSER: l = 4'd9;
			default:      l = 4'd6;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] tag_char(input logic [2:0] c, input logic [3:0] o);
		logic [71:0] t;
		logic [3:0]  k;
		unique case (c)
			TAG_ARTIST:   t = 72'("artist=");
			TAG_TITLE:    t = 72'("title=");
			TAG_ALBUM:    t = 72'("album=");
			TAG_GENRE:    t = 72'("genre=");
			TAG_COMPOSER: t = 72'("composer=");
			default:      t = '0;
		endcase
		k = tag_len(c) - 4'd1 - o;
		return (k < 4'd9) ? t[{k, 3'b000} +: 8] : 8'h00;
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
	endfunction

endpackage

// ----- src/ossp_ifs.sv -----
interface ossp_item_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [23:0] buffer_length;
	logic [7:0]  data_byte;
	modport source(output valid, kind, buffer_length, data_byte, input ready);
	modport sink(input valid, kind, buffer_length, data_byte, output ready);
endinterface

interface ossp_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         result_kind;
	logic [31:0]        sample_rate;
	logic [31:0]        coding_mode;
	logic [31:0]        channel_count;
	logic signed [31:0] nominal_bitrate;
	logic               variable_rate;
	logic [2:0]         tag_id;
	logic [7:0]         tag_byte;
	logic               is_speex;
	logic               last;
	modport source(output valid, result_kind, sample_rate, coding_mode, channel_count,
		nominal_bitrate, variable_rate, tag_id, tag_byte, is_speex, last, input ready);
	modport sink(input valid, result_kind, sample_rate, coding_mode, channel_count,
		nominal_bitrate, variable_rate, tag_id, tag_byte, is_speex, last, output ready);
endinterface

// ----- src/ossp_parser.sv -----
module ossp_parser #(
	parameter int TAG_MAX_BYTES    = ossp_pkg::TAG_MAX_BYTES_DEF,
	parameter int VENDOR_MAX_BYTES = ossp_pkg::VENDOR_MAX_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          acc,
	input  logic          kind,
	input  logic [23:0]   buffer_length,
	input  logic [7:0]    data_byte,
	output ossp_pkg::push_t push
);
	import ossp_pkg::*;

	phase_t      phase_q, n_phase;
	logic [23:0] buf_q, n_buf;
	logic [15:0] off_q, n_off;
	logic [7:0]  lace_q, n_lace;
	logic [16:0] pkt_q, n_pkt;
	logic [31:0] shift_q, n_shift;
	logic [31:0] rate_q, n_rate, mode_q, n_mode, chan_q, n_chan, brate_q, n_brate;
	logic [31:0] comm_q, n_comm;
	logic [24:0] entry_q, n_entry;
	logic [4:0]  flags_q, n_flags;
	logic [7:0]  vsent_q, n_vsent;
	logic        hdr_q, n_hdr;

	logic        dat_v, ver_v;
	result_t     dat, ver;
	logic [31:0] w;
	logic [7:0]  f;
	logic [4:0]  start_hit, value_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			buf_q <= '0;
			off_q <= '0;
			lace_q <= '0;
			pkt_q <= '0;
			shift_q <= '0;
			rate_q <= '0;
			mode_q <= '0;
			chan_q <= '0;
			brate_q <= '0;
			comm_q <= '0;
			entry_q <= '0;
			flags_q <= 5'h1f;
			vsent_q <= '0;
			hdr_q <= 1'b0;
		end else begin
			phase_q <= n_phase;
			buf_q <= n_buf;
			off_q <= n_off;
			lace_q <= n_lace;
			pkt_q <= n_pkt;
			shift_q <= n_shift;
			rate_q <= n_rate;
			mode_q <= n_mode;
			chan_q <= n_chan;
			brate_q <= n_brate;
			comm_q <= n_comm;
			entry_q <= n_entry;
			flags_q <= n_flags;
			vsent_q <= n_vsent;
			hdr_q <= n_hdr;
		end
	end

	always_comb begin
		n_phase = phase_q;
		n_buf = buf_q;
		n_off = off_q;
		n_lace = lace_q;
		n_pkt = pkt_q;
		n_shift = shift_q;
		n_rate = rate_q;
		n_mode = mode_q;
		n_chan = chan_q;
		n_brate = brate_q;
		n_comm = comm_q;
		n_entry = entry_q;
		n_flags = flags_q;
		n_vsent = vsent_q;
		n_hdr = hdr_q;
		dat_v = 1'b0;
		ver_v = 1'b0;
		dat = '0;
		ver = '0;
		start_hit = '0;
		value_hit = '0;
		w = {data_byte, shift_q[31:8]};
		f = fold(data_byte);
		if (acc) begin
			if (kind == KIND_START) begin
				n_phase = PH_P1_HDR;
				n_buf = buffer_length;
				n_off = '0;
				n_lace = '0;
				n_pkt = '0;
				n_shift = '0;
				n_rate = '0;
				n_mode = '0;
				n_chan = '0;
				n_brate = '0;
				n_comm = '0;
				n_entry = '0;
				n_flags = 5'h1f;
				n_vsent = '0;
				n_hdr = 1'b0;
				if (buffer_length < PAGE_HDR_LEN)
					ver_v = 1'b1;
			end else if (phase_q != PH_IDLE && phase_q != PH_DONE && buf_q != '0) begin
				n_buf = buf_q - 24'd1;
				n_shift = w;
				unique case (phase_q)
					PH_P1_HDR, PH_P2_HDR: begin
						if (off_q == 16'd3 && w != OGG_MAGIC) begin
							ver_v = 1'b1;
						end else if (off_q == 16'd26) begin
							if (data_byte == 8'd0 || n_buf < {16'd0, data_byte}) begin
								ver_v = 1'b1;
							end else begin
								n_lace = data_byte;
								n_pkt = '0;
								n_phase = (phase_q == PH_P1_HDR) ? PH_P1_LACE : PH_P2_LACE;
							end
						end else begin
							n_off = off_q + 16'd1;
						end
					end
					PH_P1_LACE, PH_P2_LACE: begin
						n_pkt = pkt_q + {9'd0, data_byte};
						n_lace = lace_q - 8'd1;
						if (n_lace == 8'd0) begin
							if (phase_q == PH_P1_LACE) begin
								if (n_buf < {7'd0, n_pkt} || n_pkt < SPX_HDR_MIN) begin
									ver_v = 1'b1;
								end else begin
									n_phase = PH_P1_BODY;
									n_off = '0;
								end
							end else if (n_pkt < 17'd4 || n_buf < 24'd4) begin
								ver_v = 1'b1;
							end else begin
								n_phase = PH_VEND_LEN;
								n_off = '0;
							end
						end
					end
					PH_P1_BODY: begin
						if ((off_q == 16'd3 && w != SPX_MAGIC_A) ||
							(off_q == 16'd7 && w != SPX_MAGIC_B)) begin
							ver_v = 1'b1;
						end else begin
							if (off_q == 16'd39) n_rate = w;
							if (off_q == 16'd43) n_mode = w;
							if (off_q == 16'd51) n_chan = w;
							if (off_q == 16'd55) n_brate = w;
							if (off_q == 16'd63) begin
								n_hdr = 1'b1;
								dat_v = 1'b1;
								dat.result_kind = RK_HEADER;
								dat.sample_rate = rate_q;
								dat.coding_mode = mode_q;
								dat.channel_count = chan_q;
								dat.nominal_bitrate = $signed(brate_q);
								dat.variable_rate = (w != '0);
							end
							if (off_q != 16'hffff)
								n_off = off_q + 16'd1;
							n_pkt = pkt_q - 17'd1;
							if (n_pkt == '0) begin
								if (n_buf < PAGE_HDR_LEN) begin
									ver_v = 1'b1;
								end else begin
									n_phase = PH_P2_HDR;
									n_off = '0;
								end
							end
						end
					end
					PH_VEND_LEN, PH_COUNT, PH_ENTRY_LEN: begin
						n_pkt = pkt_q - 17'd1;
						n_off = off_q + 16'd1;
						if (n_off >= 16'd4) begin
							if (phase_q == PH_VEND_LEN) begin
								if (w > 32'(VENDOR_MAX_BYTES) || {15'd0, n_pkt} < w ||
									{8'd0, n_buf} < w) begin
									ver_v = 1'b1;
								end else if (w == '0) begin
									if (n_pkt < 17'd4 || n_buf < 24'd4) begin
										ver_v = 1'b1;
									end else begin
										n_phase = PH_COUNT;
										n_off = '0;
									end
								end else begin
									n_entry = w[24:0];
									n_phase = PH_VEND_SKIP;
								end
							end else if (phase_q == PH_COUNT) begin
								n_comm = w;
								if (w == '0 || n_pkt < 17'd4 || n_buf < 24'd4) begin
									ver_v = 1'b1;
								end else begin
									n_phase = PH_ENTRY_LEN;
									n_off = '0;
								end
							end else begin
								if (w > ENTRY_MAX || {15'd0, n_pkt} < w || {8'd0, n_buf} < w) begin
									ver_v = 1'b1;
								end else if (w == '0) begin
									n_comm = comm_q - 32'd1;
									if (n_comm == '0 || n_pkt < 17'd4 || n_buf < 24'd4) begin
										ver_v = 1'b1;
									end else begin
										n_phase = PH_ENTRY_LEN;
										n_off = '0;
									end
								end else begin
									n_entry = w[24:0];
									n_flags = 5'h1f;
									n_vsent = '0;
									n_off = '0;
									n_phase = PH_ENTRY_BODY;
								end
							end
						end
					end
					PH_VEND_SKIP: begin
						n_pkt = pkt_q - 17'd1;
						n_entry = entry_q - 25'd1;
						if (n_entry == '0) begin
							if (n_pkt < 17'd4 || n_buf < 24'd4) begin
								ver_v = 1'b1;
							end else begin
								n_phase = PH_COUNT;
								n_off = '0;
							end
						end
					end
					PH_ENTRY_BODY: begin
						for (int c = 0; c < 5; c++) begin
							if (flags_q[c]) begin
								if (off_q < {12'd0, tag_len(3'(c))}) begin
									if (f != tag_char(3'(c), off_q[3:0]))
										n_flags[c] = 1'b0;
									else if (off_q + 16'd1 == {12'd0, tag_len(3'(c))})
										start_hit[c] = 1'b1;
								end else if (vsent_q < 8'(TAG_MAX_BYTES)) begin
									value_hit[c] = 1'b1;
								end
							end
						end
						for (int c = 4; c >= 0; c--) begin
							if (start_hit[c] || value_hit[c]) begin
								dat_v = 1'b1;
								dat.result_kind = start_hit[c] ? RK_TAG_START : RK_TAG_BYTE;
								dat.tag_id = 3'(c);
								dat.tag_byte = start_hit[c] ? 8'd0 : data_byte;
							end
						end
						if (value_hit != '0)
							n_vsent = vsent_q + 8'd1;
						if (off_q != 16'hffff)
							n_off = off_q + 16'd1;
						n_entry = entry_q - 25'd1;
						n_pkt = pkt_q - 17'd1;
						if (n_entry == '0) begin
							n_comm = comm_q - 32'd1;
							if (n_comm == '0 || n_pkt < 17'd4 || n_buf < 24'd4) begin
								ver_v = 1'b1;
							end else begin
								n_phase = PH_ENTRY_LEN;
								n_off = '0;
							end
						end
					end
					default: n_phase = PH_DONE;
				endcase
			end
		end
		if (ver_v) begin
			n_phase = PH_DONE;
			ver.result_kind = RK_VERDICT;
			ver.is_speex = (kind == KIND_START) ? 1'b0 : hdr_q;
			ver.last = 1'b1;
		end
		dat.last = !ver_v;
		push.n = {1'b0, dat_v} + {1'b0, ver_v};
		push.r0 = dat_v ? dat : ver;
		push.r1 = ver;
	end

endmodule

// ----- src/ossp_rqueue.sv -----
module ossp_rqueue (
	input  logic              clk,
	input  logic              arst_n,
	input  ossp_pkg::push_t   push,
	input  logic              pop,
	output logic              room,
	output logic              head_valid,
	output ossp_pkg::result_t head
);
	import ossp_pkg::*;

	localparam int AW = $clog2(RQ_DEPTH);

	result_t     mem_q [RQ_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wp_q] <= push.r0;
		if (push.n == 2'd2)
			mem_q[wp_q + AW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + AW'(push.n);
			if (pop)
				rp_q <= rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push.n) - (AW+1)'(pop);
		end
	end

	assign room = cnt_q <= (AW+1)'(RQ_DEPTH - 2);
	assign head_valid = cnt_q != '0;
	assign head = mem_q[rp_q];

endmodule

// ----- src/ogg_speex_header_tag_parser_top.sv -----
// Ogg Speex head and comment tag parser. A start item (kind 0) opens a buffer with its
// captured length; data items (kind 1) then bring its bytes. One item is accepted per
// clock: every byte is parsed in the cycle it is taken, against the parse state
// registers, and its zero, one or two results go into a four-entry result queue that
// drains one result per clock while the sink is ready. The first result can leave the
// cycle after the item is taken. Items stall only while the queue has fewer than two
// free entries, so one item per cycle holds if items average at most one result each.
// Each buffer ends with one verdict; header info and tag results come before it.
module ogg_speex_header_tag_parser_top #(
	parameter int TAG_MAX_BYTES    = ossp_pkg::TAG_MAX_BYTES_DEF,
	parameter int VENDOR_MAX_BYTES = ossp_pkg::VENDOR_MAX_BYTES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	ossp_item_if.sink   items,
	ossp_result_if.source results
);
	import ossp_pkg::*;

	push_t   push;
	result_t head;
	logic    room;
	logic    head_valid;

	assign items.ready = room;

	ossp_parser #(
		.TAG_MAX_BYTES(TAG_MAX_BYTES),
		.VENDOR_MAX_BYTES(VENDOR_MAX_BYTES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.acc(items.valid && room),
		.kind(items.kind),
		.buffer_length(items.buffer_length),
		.data_byte(items.data_byte),
		.push(push)
	);

	ossp_rqueue u_rqueue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(head_valid && results.ready),
		.room(room),
		.head_valid(head_valid),
		.head(head)
	);

	assign results.valid = head_valid;
	assign results.result_kind = head.result_kind;
	assign results.sample_rate = head.sample_rate;
	assign results.coding_mode = head.coding_mode;
	assign results.channel_count = head.channel_count;
	assign results.nominal_bitrate = head.nominal_bitrate;
	assign results.variable_rate = head.variable_rate;
	assign results.tag_id = head.tag_id;
	assign results.tag_byte = head.tag_byte;
	assign results.is_speex = head.is_speex;
	assign results.last = head.last;

endmodule

// ----- tb/ossp_checker.sv -----
`timescale 1ns / 1ps

module ossp_checker
	import ossp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	ossp_item_if    items,
	ossp_result_if  results,
	output int      errors,
	output int      pending,
	output int      checked
);

	localparam int unsigned TAG_CAP    = 127;
	localparam int unsigned VENDOR_CAP = 1024;

	result_t       expected_results[$];
	phase_t        ph;
	logic [23:0]   buf_left;
	logic [15:0]   sec_off;
	logic [7:0]    laces;
	logic [31:0]   pkt_left;
	logic [31:0]   shifter;
	logic [31:0]   hdr_word[5];
	logic [31:0]   comments;
	logic [31:0]   entry_left;
	logic [4:0]    alive;
	logic [7:0]    sent;
	logic          hdr_ok;
	int            step_n;
	string         tag_names[5] = '{"artist=", "title=", "album=", "genre=", "composer="};

	task automatic push_result(input result_t r);
		expected_results.push_back(r);
		step_n++;
	endtask

	task automatic give_verdict();
		result_t r;
		r = '0;
		r.result_kind = RK_VERDICT;
		r.is_speex = hdr_ok;
		push_result(r);
		ph = PH_DONE;
	endtask

	task automatic want_word(input phase_t nxt);
		if (pkt_left < 4 || buf_left < 4) begin
			give_verdict();
		end else begin
			ph = nxt;
			sec_off = 0;
		end
	endtask

	task automatic after_entry();
		if (comments == 0) begin
			give_verdict();
		end else begin
			want_word(PH_ENTRY_LEN);
		end
	endtask

	task automatic clear_state();
		ph = PH_IDLE;
		buf_left = 0;
		sec_off = 0;
		laces = 0;
		pkt_left = 0;
		shifter = 0;
		foreach (hdr_word[i]) hdr_word[i] = 0;
		comments = 0;
		entry_left = 0;
		alive = 5'h1f;
		sent = 0;
		hdr_ok = 0;
	endtask

	task automatic page_head_byte(input logic [7:0] b, input phase_t lace_ph);
		if (sec_off == 3 && shifter != OGG_MAGIC) begin
			give_verdict();
		end else if (sec_off == 26) begin
			if (b == 0 || buf_left < b) begin
				give_verdict();
			end else begin
				laces = b;
				pkt_left = 0;
				ph = lace_ph;
			end
		end else begin
			sec_off++;
		end
	endtask

	task automatic entry_body_byte(input logic [7:0] b);
		logic [7:0] f;
		result_t    r;
		f = (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
		for (int c = 0; c < 5; c++) begin
			if (!alive[c]) continue;
			if (sec_off < tag_names[c].len()) begin
				if (f != tag_names[c][sec_off]) begin
					alive[c] = 1'b0;
				end else if (sec_off + 1 == tag_names[c].len()) begin
					r = '0;
					r.result_kind = RK_TAG_START;
					r.tag_id = 3'(c);
					push_result(r);
				end
			end else if (sent < TAG_CAP) begin
				r = '0;
				r.result_kind = RK_TAG_BYTE;
				r.tag_id = 3'(c);
				r.tag_byte = b;
				push_result(r);
				sent++;
			end
		end
		if (sec_off != 16'hffff) sec_off++;
		entry_left--;
		pkt_left--;
		if (entry_left == 0) begin
			comments--;
			after_entry();
		end
	endtask

	task automatic predict_byte(input logic [7:0] b);
		logic [31:0] w;
		result_t     r;
		if (ph == PH_IDLE || ph == PH_DONE || buf_left == 0) return;
		buf_left--;
		shifter = {b, shifter[31:8]};
		w = shifter;
		case (ph)
			PH_P1_HDR: page_head_byte(b, PH_P1_LACE);
			PH_P2_HDR: page_head_byte(b, PH_P2_LACE);
			PH_P1_LACE, PH_P2_LACE: begin
				pkt_left += b;
				laces--;
				if (laces == 0) begin
					if (ph == PH_P1_LACE) begin
						if (buf_left < pkt_left || pkt_left < SPX_HDR_MIN) begin
							give_verdict();
						end else begin
							ph = PH_P1_BODY;
							sec_off = 0;
						end
					end else begin
						want_word(PH_VEND_LEN);
					end
				end
			end
			PH_P1_BODY: begin
				if ((sec_off == 3 && w != SPX_MAGIC_A) || (sec_off == 7 && w != SPX_MAGIC_B)) begin
					give_verdict();
				end else begin
					if (sec_off == 39) hdr_word[0] = w;
					if (sec_off == 43) hdr_word[1] = w;
					if (sec_off == 51) hdr_word[2] = w;
					if (sec_off == 55) hdr_word[3] = w;
					if (sec_off == 63) begin
						hdr_word[4] = w;
						hdr_ok = 1'b1;
						r = '0;
						r.result_kind = RK_HEADER;
						r.sample_rate = hdr_word[0];
						r.coding_mode = hdr_word[1];
						r.channel_count = hdr_word[2];
						r.nominal_bitrate = hdr_word[3];
						r.variable_rate = (hdr_word[4] != 0);
						push_result(r);
					end
					if (sec_off != 16'hffff) sec_off++;
					pkt_left--;
					if (pkt_left == 0) begin
						if (buf_left < PAGE_HDR_LEN) begin
							give_verdict();
						end else begin
							ph = PH_P2_HDR;
							sec_off = 0;
						end
					end
				end
			end
			PH_VEND_LEN, PH_COUNT, PH_ENTRY_LEN: begin
				pkt_left--;
				sec_off++;
				if (sec_off >= 4) begin
					if (ph == PH_VEND_LEN) begin
						if (w > VENDOR_CAP || pkt_left < w || buf_left < w) begin
							give_verdict();
						end else if (w == 0) begin
							want_word(PH_COUNT);
						end else begin
							entry_left = w;
							ph = PH_VEND_SKIP;
						end
					end else if (ph == PH_COUNT) begin
						comments = w;
						after_entry();
					end else begin
						if (w > ENTRY_MAX || pkt_left < w || buf_left < w) begin
							give_verdict();
						end else if (w == 0) begin
							comments--;
							after_entry();
						end else begin
							entry_left = w;
							alive = 5'h1f;
							sent = 0;
							sec_off = 0;
							ph = PH_ENTRY_BODY;
						end
					end
				end
			end
			PH_VEND_SKIP: begin
				pkt_left--;
				entry_left--;
				if (entry_left == 0) want_word(PH_COUNT);
			end
			PH_ENTRY_BODY: entry_body_byte(b);
			default: ph = PH_DONE;
		endcase
	endtask

	task automatic predict_item(input logic kind, input logic [23:0] len, input logic [7:0] b);
		step_n = 0;
		if (kind == KIND_START) begin
			clear_state();
			buf_left = len;
			if (buf_left < PAGE_HDR_LEN) begin
				give_verdict();
			end else begin
				ph = PH_P1_HDR;
			end
		end else begin
			predict_byte(b);
		end
		if (step_n > 0) expected_results[$].last = 1'b1;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			errors = 0;
			pending = 0;
			checked = 0;
			clear_state();
		end else begin
			if (items.valid && items.ready) begin
				predict_item(items.kind, items.buffer_length, items.data_byte);
			end
			if (results.valid && results.ready) begin
				checked++;
				if (expected_results.size() == 0) begin
					$error("result of kind %0d with no expectation waiting", results.result_kind);
					errors++;
				end else begin
					e = expected_results.pop_front();
					check_field("result_kind", e.result_kind, results.result_kind);
					check_field("sample_rate", e.sample_rate, results.sample_rate);
					check_field("coding_mode", e.coding_mode, results.coding_mode);
					check_field("channel_count", e.channel_count, results.channel_count);
					check_field("nominal_bitrate", e.nominal_bitrate, results.nominal_bitrate);
					check_field("variable_rate", e.variable_rate, results.variable_rate);
					check_field("tag_id", e.tag_id, results.tag_id);
					check_field("tag_byte", e.tag_byte, results.tag_byte);
					check_field("is_speex", e.is_speex, results.is_speex);
					check_field("last", e.last, results.last);
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// ----- tb/ogg_speex_header_tag_parser_top_test.sv -----
`timescale 1ns / 1ps

module ogg_speex_header_tag_parser_top_test;
	import ossp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic took = 0;
	logic calm = 0;
	int   errors, pending, checked;
	int   cycles = 0;
	int   items_sent = 0;
	int   buffers_sent = 0;
	byte unsigned stream_q[$];
	byte unsigned packet_q[$];
	string tag_names[7] = '{"artist=", "title=", "album=", "genre=", "composer=", "lyric=", "art"};

	ossp_item_if   items();
	ossp_result_if results();

	ogg_speex_header_tag_parser_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.results(results)
	);

	ossp_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.results(results),
		.errors(errors),
		.pending(pending),
		.checked(checked)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		took <= items.valid && items.ready;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("ogg_speex_header_tag_parser_top_test: done, errors");
			$finish;
		end
	end

	initial begin
		results.ready = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(3) == 0) begin
				results.ready = 0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			results.ready = 1;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
	end

	task automatic send_item(input logic kind, input logic [23:0] len, input logic [7:0] b);
		if (!calm && $urandom_range(7) == 0) begin
			items.valid = 0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		items.valid = 1;
		items.kind = kind;
		items.buffer_length = len;
		items.data_byte = b;
		do @(negedge clk); while (!took);
		items_sent++;
	endtask

	task automatic put_word(input int unsigned w);
		for (int i = 0; i < 4; i++) packet_q.push_back(8'(w >> (8 * i)));
	endtask

	task automatic put_page(input int unsigned plen);
		byte unsigned lace[$];
		int unsigned  rem, a;
		rem = plen;
		if (plen < 255 && $urandom_range(1)) begin
			a = $urandom_range(plen);
			lace.push_back(8'(a));
			lace.push_back(8'(plen - a));
		end else begin
			while (rem >= 255) begin
				lace.push_back(8'd255);
				rem -= 255;
			end
			lace.push_back(8'(rem));
		end
		stream_q.push_back(8'h4f);
		stream_q.push_back(8'h67);
		stream_q.push_back(8'h67);
		stream_q.push_back(8'h53);
		repeat (22) stream_q.push_back(8'($urandom_range(255)));
		stream_q.push_back(8'(lace.size()));
		foreach (lace[i]) stream_q.push_back(lace[i]);
	endtask

	// every_tag: each tag name once, two repeats and a partial name, upper case, long value
	task automatic build_file(input bit every_tag, input int vend_len);
		string        nm;
		byte unsigned ch;
		int           p1, n, k, vlen, vend;
		p1 = 80 + $urandom_range(20);
		stream_q.delete();
		put_page(p1);
		packet_q.delete();
		packet_q = '{"S", "p", "e", "e", "x", " ", " ", " "};
		repeat (p1 - 8) packet_q.push_back(8'($urandom_range(255)));
		if ($urandom_range(1)) for (int i = 60; i < 64; i++) packet_q[i] = 0;
		stream_q = {stream_q, packet_q};
		packet_q.delete();
		vend = (vend_len >= 0) ? vend_len : $urandom_range(0, 12);
		put_word(vend);
		repeat (vend) packet_q.push_back(8'($urandom_range(255)));
		n = every_tag ? 8 : $urandom_range(0, 5);
		put_word(n + ((!every_tag && $urandom_range(7) == 0) ? 1 : 0));
		for (int e = 0; e < n; e++) begin
			if (!every_tag && $urandom_range(9) == 0) begin
				put_word(0);
				continue;
			end
			k = every_tag ? (e < 7 ? e % 5 : 6) : $urandom_range(6);
			nm = tag_names[k];
			vlen = (every_tag && e == 1) ? 135 : $urandom_range(0, 8);
			if (every_tag && e == 5) vlen = 0;
			put_word(nm.len() + vlen);
			foreach (nm[i]) begin
				ch = nm[i];
				if (ch >= 8'h61 && (every_tag ? e >= 5 : $urandom_range(1))) ch ^= 8'h20;
				packet_q.push_back(ch);
			end
			repeat (vlen) packet_q.push_back(8'($urandom_range(255)));
		end
		put_page(packet_q.size());
		stream_q = {stream_q, packet_q};
	endtask

	// mode 0 exact length, 1 cut short, 2 longer than sent, 3 random length
	task automatic send_buffer(input int mode);
		int unsigned len;
		case (mode)
			0: len = stream_q.size();
			1: len = $urandom_range(stream_q.size());
			2: len = stream_q.size() + $urandom_range(1, 300);
			default: len = $urandom_range(24'hffffff);
		endcase
		send_item(KIND_START, 24'(len), 8'($urandom_range(255)));
		foreach (stream_q[i])
			send_item(KIND_DATA, 24'($urandom_range(24'hffffff)), stream_q[i]);
		buffers_sent++;
	endtask

	initial begin
		int r;
		items.valid = 0;
		items.kind = KIND_START;
		items.buffer_length = 0;
		items.data_byte = 0;
		repeat (10) @(posedge clk);
		arst_n = 1;
		@(negedge clk);

		send_item(KIND_DATA, 0, 8'hff);
		send_item(KIND_DATA, 24'hffffff, 8'h00);
		send_item(KIND_START, 0, 0);
		send_item(KIND_START, 26, 0);
		send_item(KIND_START, 27, 0);
		repeat (27) send_item(KIND_DATA, 0, 8'h4f);
		send_item(KIND_START, 24'hffffff, 0);
		repeat (12) send_item(KIND_DATA, 0, 8'($urandom_range(255)));
		build_file(1, -1);
		send_buffer(0);
		send_item(KIND_DATA, 0, 8'haa);
		// vendor length over the limit, buffer ends after the length word
		build_file(0, 1025);
		stream_q = stream_q[0:stream_q.size() - packet_q.size() + 3];
		send_buffer(0);

		while (items_sent < 650) begin
			if (items_sent > 500) calm = 1;
			build_file(0, -1);
			r = $urandom_range(15);
			if (r < 2) stream_q[$urandom_range(stream_q.size() - 1)] = 8'($urandom_range(255));
			send_buffer(r < 10 ? 0 : r < 13 ? 1 : r < 15 ? 2 : 3);
		end
		items.valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		$display("%0d items in %0d buffers sent, %0d results checked",
			items_sent, buffers_sent, checked);
		if (errors == 0 && pending == 0) begin
			$display("ogg_speex_header_tag_parser_top_test: done, clean");
		end else begin
			$display("ogg_speex_header_tag_parser_top_test: done, errors");
		end
		$finish;
	end

endmodule
